// ===== hdl/jetp_pkg.sv =====
// Package for the Julia escape-time pixel block: widths, register indexes,
// reset values, palette table, shared types and saturation helper.
// No dependencies.
`default_nettype none

package jetp_pkg;

	// number formats
	localparam int VAL_W      = 32;              // Q4.28 coordinate register
	localparam int FRAC_BITS  = 28;
	localparam int COORD_BITS = 12;
	localparam int STEP_BITS  = 31;
	localparam int ITER_BITS  = 12;
	localparam int CNT_W      = ITER_BITS + 1;
	localparam int PAL_SIZE   = 12;
	localparam int IDX_W      = 4;
	localparam int COLOR_W    = 32;
	localparam int PROD_W     = 2 * VAL_W;       // full-width square
	localparam int SUM_W      = PROD_W + 1;      // headroom before saturation
	localparam int MAP_W      = COORD_BITS + STEP_BITS;
	localparam int NUM_W      = ITER_BITS + $clog2(PAL_SIZE);

	// escape threshold 4.0 in the square domain; wider than the word means never
	localparam int TSHIFT = 2 + 2 * FRAC_BITS;
	localparam logic [PROD_W-1:0] THRESH =
		(TSHIFT >= PROD_W) ? '1 : (PROD_W'(1) << TSHIFT);

	// start-point queue
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_C_REAL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C_IMAG    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_EDGE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_NO_REPEAT = 3'd7;

	localparam logic signed [VAL_W-1:0] RST_C_REAL    = -32'sd198642237;
	localparam logic signed [VAL_W-1:0] RST_C_IMAG    = 32'sd26843546;
	localparam logic signed [VAL_W-1:0] RST_LEFT_EDGE = -32'sd536870912;
	localparam logic signed [VAL_W-1:0] RST_TOP_EDGE  = 32'sd536870912;
	localparam logic [STEP_BITS-1:0]    RST_STEP      = 31'd3579139;
	localparam logic [ITER_BITS-1:0]    RST_ITER_LIM  = 12'd1000;

	localparam logic [COLOR_W-1:0] BLACK = 32'hFF00_0000;

	localparam logic [COLOR_W-1:0] PALETTE [PAL_SIZE] = '{
		32'hFFEEC73E, 32'hFFF0A513, 32'hFFFB8B00, 32'hFFF44800,
		32'hFFFFFF99, 32'hFFFFFF00, 32'hFFFDCA01, 32'hFF986601,
		32'hFFF44800, 32'hFFFD3301, 32'hFFD40000, 32'hFF980101
	};

	typedef struct packed {
		logic signed [VAL_W-1:0] c_real;
		logic signed [VAL_W-1:0] c_imag;
		logic signed [VAL_W-1:0] left_edge;
		logic signed [VAL_W-1:0] top_edge;
		logic [STEP_BITS-1:0]    step_x;
		logic [STEP_BITS-1:0]    step_y;
		logic [ITER_BITS-1:0]    iteration_limit;
		logic                    no_repeat_mode;
	} cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] x;
		logic signed [VAL_W-1:0] y;
	} point_t;

	typedef enum logic [1:0] {
		IT_IDLE,
		IT_MUL,
		IT_ADD,
		IT_DONE
	} it_state_t;

	typedef enum logic [1:0] {
		SH_IDLE,
		SH_DIV,
		SH_FIN,
		SH_OUT
	} sh_state_t;

	// clamp a wide signed sum into the coordinate register range
	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
		logic fits;
		fits = (&v[SUM_W-1:VAL_W-1]) | ~(|v[SUM_W-1:VAL_W-1]);
		if (fits)
			return v[VAL_W-1:0];
		else if (v[SUM_W-1])
			return {1'b1, {(VAL_W-1){1'b0}}};
		else
			return {1'b0, {(VAL_W-1){1'b1}}};
	endfunction

	function automatic logic [COLOR_W-1:0] pal_color(input logic [IDX_W-1:0] idx);
		if (idx < IDX_W'(PAL_SIZE))
			return PALETTE[idx];
		else
			return '0;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/julia_escape_time_pixel.sv =====
// Top level of the Julia escape-time pixel block: configuration registers,
// front end, start-point queue, iteration engine and shading back end.
// Uses jetp_pkg, jetp_front, jetp_queue, jetp_iter, jetp_shade.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  pixel in | in        | in_valid / in_stall       | pixel_x, pixel_y
//  result   | out       | out_valid / out_stall     | pixel_color, iteration_count,
//           |           |                           | inside_set, palette_index
//  config   | in        | cfg_write (no handshake)  | cfg_index, cfg_data
//
// A pixel escaping at index k holds the iteration engine for a pop state, a 32x32
// multiply state and an add/saturate state for the start point and each of k+1
// iterations, and a hand-off state; inside pixels run limit+1 iterations. Shading
// runs its 16-step divider for escaped pixels only, skips it for inside ones, and
// overlaps the engine's work on the next pixel.
// Reset clears all control state and loads the default configuration.
// out_stall holds the result register; the engine finishes its next pixel and
// waits, and in_stall rises once the queue and the front stage are full.
`default_nettype none

module julia_escape_time_pixel import jetp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [VAL_W-1:0]      cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [COLOR_W-1:0]         pixel_color,
	output logic [CNT_W-1:0]           iteration_count,
	output logic                       inside_set,
	output logic [IDX_W-1:0]           palette_index
);

	cfg_t   cfg_q;
	logic   push, full, pop, head_valid;
	point_t push_data, head_data;
	logic   res_valid, res_take;
	logic [CNT_W-1:0] res_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.c_real          <= RST_C_REAL;
			cfg_q.c_imag          <= RST_C_IMAG;
			cfg_q.left_edge       <= RST_LEFT_EDGE;
			cfg_q.top_edge        <= RST_TOP_EDGE;
			cfg_q.step_x          <= RST_STEP;
			cfg_q.step_y          <= RST_STEP;
			cfg_q.iteration_limit <= RST_ITER_LIM;
			cfg_q.no_repeat_mode  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_C_REAL:    cfg_q.c_real          <= cfg_data;
				REG_C_IMAG:    cfg_q.c_imag          <= cfg_data;
				REG_LEFT_EDGE: cfg_q.left_edge       <= cfg_data;
				REG_TOP_EDGE:  cfg_q.top_edge        <= cfg_data;
				REG_STEP_X:    cfg_q.step_x          <= cfg_data[STEP_BITS-1:0];
				REG_STEP_Y:    cfg_q.step_y          <= cfg_data[STEP_BITS-1:0];
				REG_ITER_LIM:  cfg_q.iteration_limit <= cfg_data[ITER_BITS-1:0];
				REG_NO_REPEAT: cfg_q.no_repeat_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	jetp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	jetp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	jetp_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (head_valid),
		.q_data    (head_data),
		.q_pop     (pop),
		.res_valid (res_valid),
		.res_count (res_count),
		.res_take  (res_take)
	);

	jetp_shade u_shade (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.res_valid       (res_valid),
		.res_count       (res_count),
		.res_take        (res_take),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_color     (pixel_color),
		.iteration_count (iteration_count),
		.inside_set      (inside_set),
		.palette_index   (palette_index)
	);

endmodule

`default_nettype wire

// ===== hdl/jetp_front.sv =====
// Front end: accepts pixel transactions and maps them to complex start points.
// Uses jetp_pkg; feeds jetp_queue.
`default_nettype none

module jetp_front import jetp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_BITS-1:0] pixel_x,
	input  wire logic [COORD_BITS-1:0] pixel_y,
	output logic                       push,
	output point_t                     push_data,
	input  wire logic                  full
);

	logic              valid_s1;
	logic [MAP_W-1:0]  prod_x_s1;
	logic [MAP_W-1:0]  prod_y_s1;
	logic              accept;
	logic [STEP_BITS-1:0] step_x;
	logic [STEP_BITS-1:0] step_y;
	logic signed [SUM_W-1:0] ext_left;
	logic signed [SUM_W-1:0] ext_top;
	logic signed [SUM_W-1:0] ext_px;
	logic signed [SUM_W-1:0] ext_py;

	assign step_x   = cfg.step_x;
	assign step_y   = cfg.step_y;
	assign in_stall = valid_s1 & full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prod_x_s1 <= MAP_W'(pixel_x) * MAP_W'(step_x);
			prod_y_s1 <= MAP_W'(pixel_y) * MAP_W'(step_y);
		end
	end

	always_comb begin
		ext_left    = SUM_W'(cfg.left_edge);
		ext_top     = SUM_W'(cfg.top_edge);
		ext_px      = SUM_W'(prod_x_s1);
		ext_py      = SUM_W'(prod_y_s1);
		push_data.x = sat_val(ext_left + ext_px);
		push_data.y = sat_val(ext_top - ext_py);
	end

endmodule

`default_nettype wire

// ===== hdl/jetp_queue.sv =====
// Short start-point queue between front end and iteration engine.
// Uses jetp_pkg (point_t, QDEPTH).
`default_nettype none

module jetp_queue import jetp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  wire point_t push_data,
	output logic        full,
	input  wire logic   pop,
	output logic        head_valid,
	output point_t      head_data
);

	point_t         mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;

	assign full       = (cnt_q == (QAW+1)'(QDEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == QAW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == QAW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			if (push & ~pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop & ~push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue push while full");

endmodule

`default_nettype wire

// ===== hdl/jetp_iter.sv =====
// Iteration engine: z = z^2 + c with saturation, escape test on full squares.
// Uses jetp_pkg; pops jetp_queue, hands counts to jetp_shade.
`default_nettype none

module jetp_iter import jetp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   q_valid,
	input  wire point_t q_data,
	output logic        q_pop,
	output logic        res_valid,
	output logic [CNT_W-1:0] res_count,
	input  wire logic   res_take
);

	it_state_t state_q, state_d;

	logic signed [VAL_W-1:0]  x_q, y_q;
	logic signed [PROD_W-1:0] p_xx_q, p_yy_q, p_xy_q;
	logic [CNT_W-1:0]         k_q;
	logic                     first_q;

	logic signed [VAL_W-1:0]  c_re, c_im;
	logic signed [PROD_W-1:0] diff;
	logic signed [SUM_W-1:0]  re_sum, im_sum;
	logic signed [VAL_W-1:0]  nx, ny;
	logic [PROD_W-1:0]        mag;
	logic                     escaped;
	logic                     at_limit;

	always_comb begin
		c_re     = cfg.c_real;
		c_im     = cfg.c_imag;
		diff     = p_xx_q - p_yy_q;
		re_sum   = SUM_W'(diff >>> FRAC_BITS) + SUM_W'(c_re);
		im_sum   = SUM_W'(p_xy_q >>> (FRAC_BITS - 1)) + SUM_W'(c_im);
		nx       = sat_val(re_sum);
		ny       = sat_val(im_sum);
		// squares of the current point test the previous update
		mag      = $unsigned(p_xx_q) + $unsigned(p_yy_q);
		escaped  = (mag > THRESH);
		at_limit = (k_q == {1'b0, cfg.iteration_limit});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= IT_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			IT_IDLE: begin
				q_pop = q_valid;
				if (q_valid)
					state_d = IT_MUL;
			end
			IT_MUL: begin
				state_d = IT_ADD;
			end
			IT_ADD: begin
				if (!first_q && (escaped || at_limit))
					state_d = IT_DONE;
				else
					state_d = IT_MUL;
			end
			IT_DONE: begin
				res_valid = 1'b1;
				if (res_take)
					state_d = IT_IDLE;
			end
			default: state_d = IT_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				IT_IDLE: begin
					if (q_valid) begin
						k_q     <= '0;
						first_q <= 1'b1;
					end
				end
				IT_ADD: begin
					if (first_q)
						first_q <= 1'b0;
					else if (!escaped)
						k_q <= k_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IT_IDLE: begin
				if (q_valid) begin
					x_q <= q_data.x;
					y_q <= q_data.y;
				end
			end
			IT_MUL: begin
				p_xx_q <= PROD_W'(x_q) * PROD_W'(x_q);
				p_yy_q <= PROD_W'(y_q) * PROD_W'(y_q);
				p_xy_q <= PROD_W'(x_q) * PROD_W'(y_q);
			end
			IT_ADD: begin
				if (first_q || !(escaped || at_limit)) begin
					x_q <= nx;
					y_q <= ny;
				end
			end
			default: ;
		endcase
	end

	assign res_count = k_q;

	a_k_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IT_ADD) |-> (k_q <= {1'b0, cfg.iteration_limit}))
		else $error("iteration index past limit");

endmodule

`default_nettype wire

// ===== hdl/jetp_shade.sv =====
// Shading back end: inside test, palette index by shared restoring divider,
// palette lookup and the output register. Uses jetp_pkg.
`default_nettype none

module jetp_shade import jetp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire logic             res_valid,
	input  wire logic [CNT_W-1:0] res_count,
	output logic                  res_take,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [COLOR_W-1:0]    pixel_color,
	output logic [CNT_W-1:0]      iteration_count,
	output logic                  inside_set,
	output logic [IDX_W-1:0]      palette_index
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	sh_state_t state_q, state_d;

	logic [NUM_W-1:0]     num_q;   // dividend in, quotient out
	logic [ITER_BITS-1:0] den_q;
	logic [ITER_BITS-1:0] rem_q;
	logic [STEP_W-1:0]    step_q;
	logic [COLOR_W-1:0]   color_q;
	logic [CNT_W-1:0]     count_q;
	logic                 inside_q;
	logic [IDX_W-1:0]     idx_q;

	logic                 is_inside;
	logic [ITER_BITS:0]   trial;
	logic                 fits;
	logic [IDX_W-1:0]     idx_d;

	always_comb begin
		is_inside = (res_count >= {1'b0, cfg.iteration_limit});
		trial     = {rem_q, num_q[NUM_W-1]};
		fits      = (trial >= {1'b0, den_q});
		idx_d     = cfg.no_repeat_mode ? num_q[IDX_W-1:0] : rem_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SH_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		res_take  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			SH_IDLE: begin
				res_take = 1'b1;
				if (res_valid)
					state_d = is_inside ? SH_OUT : SH_DIV;
			end
			SH_DIV: begin
				if (step_q == STEP_W'(1))
					state_d = SH_FIN;
			end
			SH_FIN: begin
				state_d = SH_OUT;
			end
			SH_OUT: begin
				out_valid = 1'b1;
				if (!out_stall)
					state_d = SH_IDLE;
			end
			default: state_d = SH_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SH_IDLE: begin
				if (res_valid) begin
					count_q  <= res_count;
					inside_q <= is_inside;
					color_q  <= BLACK;
					idx_q    <= '0;
					rem_q    <= '0;
					step_q   <= STEP_W'(NUM_W);
					// not inside means count < limit, so it fits ITER_BITS
					if (cfg.no_repeat_mode) begin
						num_q <= NUM_W'(PAL_SIZE) * NUM_W'(res_count[ITER_BITS-1:0]);
						den_q <= cfg.iteration_limit;
					end else begin
						num_q <= NUM_W'(res_count[ITER_BITS-1:0]);
						den_q <= ITER_BITS'(PAL_SIZE);
					end
				end
			end
			SH_DIV: begin
				rem_q  <= fits ? ITER_BITS'(trial - {1'b0, den_q}) : trial[ITER_BITS-1:0];
				num_q  <= {num_q[NUM_W-2:0], fits};
				step_q <= step_q - 1'b1;
			end
			SH_FIN: begin
				idx_q   <= idx_d;
				color_q <= pal_color(idx_d);
			end
			default: ;
		endcase
	end

	assign pixel_color     = color_q;
	assign iteration_count = count_q;
	assign inside_set      = inside_q;
	assign palette_index   = idx_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (palette_index < IDX_W'(PAL_SIZE)))
		else $error("palette index out of range");

	a_outside_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !inside_set) |-> (iteration_count < {1'b0, cfg.iteration_limit}))
		else $error("escaped pixel with count at or past limit");

	a_inside_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && inside_set) |-> (pixel_color == BLACK && palette_index == '0))
		else $error("inside pixel not black");

endmodule

`default_nettype wire
